### rtl/core/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

    // Pad character appended to a short final group.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Place of the next byte within its three-byte group, one-hot.
    typedef enum logic [2:0] {
        POS0 = 3'b001,
        POS1 = 3'b010,
        POS2 = 3'b100
    } group_pos_t;

    // Characters produced by one byte, queued between front and back.
    // chars[0] goes out first; last_idx is the index of the final valid
    // character, and msg_end marks that the entry's final character ends the message.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            msg_end;
    } entry_t;

    // Maps a six-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62) begin
            c = 8'h2B;
        end
        else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/b64e_if.sv
`default_nettype none

// Raw byte channel into the encoder.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Encoded character channel out of the encoder.
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

### rtl/core/b64e_front.sv
`default_nettype none

module b64e_front (
    input  wire              clk,
    input  wire              rst_n,
    b64e_byte_if.sink        byte_in,
    input  wire              fifo_full,
    output logic             push,
    output b64e_pkg::entry_t entry
);

    b64e_pkg::group_pos_t pos_reg;
    b64e_pkg::group_pos_t pos_next;
    logic [3:0]           left_reg;
    logic [3:0]           left_next;
    logic [7:0]           b;

    assign byte_in.ready = !fifo_full;
    assign push          = byte_in.valid && !fifo_full;
    assign b             = byte_in.data_byte;

    // Classify the byte by its group place and build its characters.
    always_comb
    begin
        entry.chars    = '0;
        entry.last_idx = 2'd0;
        entry.msg_end  = 1'b0;
        pos_next       = pos_reg;
        left_next      = left_reg;
        case (pos_reg)
            b64e_pkg::POS1:
            begin
                entry.chars[0] = b64e_pkg::b64_sym({left_reg[1:0], b[7:4]});
                if (byte_in.final_byte)
                begin
                    entry.chars[1] = b64e_pkg::b64_sym({b[3:0], 2'b00});
                    entry.chars[2] = b64e_pkg::PAD_CHAR;
                    entry.last_idx = 2'd2;
                    entry.msg_end  = 1'b1;
                    pos_next       = b64e_pkg::POS0;
                    left_next      = 4'd0;
                end
                else
                begin
                    pos_next  = b64e_pkg::POS2;
                    left_next = b[3:0];
                end
            end
            b64e_pkg::POS2:
            begin
                entry.chars[0] = b64e_pkg::b64_sym({left_reg, b[7:6]});
                entry.chars[1] = b64e_pkg::b64_sym(b[5:0]);
                entry.last_idx = 2'd1;
                entry.msg_end  = byte_in.final_byte;
                pos_next       = b64e_pkg::POS0;
                left_next      = 4'd0;
            end
            default:
            begin
                // Start of a group; an illegal place code is treated the same.
                entry.chars[0] = b64e_pkg::b64_sym(b[7:2]);
                if (byte_in.final_byte)
                begin
                    entry.chars[1] = b64e_pkg::b64_sym({b[1:0], 4'b0000});
                    entry.chars[2] = b64e_pkg::PAD_CHAR;
                    entry.chars[3] = b64e_pkg::PAD_CHAR;
                    entry.last_idx = 2'd3;
                    entry.msg_end  = 1'b1;
                    pos_next       = b64e_pkg::POS0;
                    left_next      = 4'd0;
                end
                else
                begin
                    pos_next  = b64e_pkg::POS1;
                    left_next = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    // Group state advances only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= b64e_pkg::POS0;
            left_reg <= 4'd0;
        end
        else if (push)
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

    // A final byte always returns the encoder to the start of a group.
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && byte_in.final_byte) |=> (pos_reg == b64e_pkg::POS0 && left_reg == 4'd0))
        else $error("group state not cleared after final byte");

endmodule

`default_nettype wire

### rtl/core/b64e_fifo.sv
`default_nettype none

module b64e_fifo #(
    parameter int DEPTH = 2
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire b64e_pkg::entry_t push_entry,
    input  wire              pop,
    output b64e_pkg::entry_t head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

### rtl/core/b64e_back.sv
`default_nettype none

module b64e_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire b64e_pkg::entry_t head,
    input  wire              fifo_empty,
    output logic             pop,
    b64e_char_if.source      char_out
);

    b64e_pkg::entry_t cur_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_char_reg;
    logic             last_char_reg;
    logic             out_free;
    logic             advance;
    logic             cur_done;

    assign out_free = !out_valid_reg || char_out.ready;
    assign advance  = cur_valid_reg && out_free;
    assign cur_done = advance && (idx_reg == cur_reg.last_idx);
    assign pop      = !fifo_empty && (!cur_valid_reg || cur_done);

    assign char_out.valid     = out_valid_reg;
    assign char_out.out_char  = out_char_reg;
    assign char_out.last_char = last_char_reg;

    // Walk the characters of the current entry, one per output transfer slot.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // The output register empties when its transfer completes with nothing behind it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (char_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (advance)
        begin
            out_char_reg  <= cur_reg.chars[idx_reg];
            last_char_reg <= cur_reg.msg_end && (idx_reg == cur_reg.last_idx);
        end
    end

    a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= cur_reg.last_idx))
        else $error("character index past end of entry");

endmodule

`default_nettype wire

### rtl/core/base64_stream_encoder_top.sv
// Channel    Dir  Payload                        Meaning
// byte_in    in   data_byte[7:0], final_byte     raw message byte, end-of-message flag
// char_out   out  out_char[7:0], last_char       base64 character or pad, last flag
//
// A byte is taken whenever the queue has room, and characters leave one per cycle
// while char_out is ready; a byte yields 1 to 4 characters, and a long message
// is paced by the single character output port.
// A first character passes the queue slot, current-entry register and output register.
// Reset clears the group state, the queue and the output register.
// The byte and character sides stall independently through a FIFO_DEPTH entry queue.
`default_nettype none

module base64_stream_encoder_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire         clk,
    input  wire         rst_n,
    b64e_byte_if.sink   byte_in,
    b64e_char_if.source char_out
);

    b64e_pkg::entry_t push_entry;
    b64e_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             fifo_full;
    logic             fifo_empty;

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .fifo_full (fifo_full),
        .push      (push),
        .entry     (push_entry)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .char_out   (char_out)
    );

endmodule

`default_nettype wire
